// ===== rtl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the csv field tokenizer: parse modes, the
// input item, the result item and the group of results one byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic [7:0] DELIM_RESET = 8'h2C;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef enum logic [2:0] {
    MODE_FIELD_START = 3'd0,
    MODE_UNQUOTED    = 3'd1,
    MODE_FULL        = 3'd2,
    MODE_QUOTED      = 3'd3,
    MODE_QUOTE_SEEN  = 3'd4,
    MODE_SKIP        = 3'd5,
    MODE_EOL_SKIP    = 3'd6,
    MODE_AFTER_CR    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic       write_valid;
    logic [4:0] column;
    logic [7:0] position;
    logic [7:0] value_byte;
    logic       field_done;
    logic [7:0] field_length;
    logic       quoted_field;
    logic       row_done;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/csvt_in_reg.sv =====
// ----------------------------------------------------------------------------
// csvt_in_reg
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_data,
  input  wire logic          take,
  output logic               item_valid,
  output csvt_pkg::item_t    item
);

  logic load;

  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.data_byte   <= data_byte;
      item.end_of_data <= end_of_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csvt_parser.sv =====
// ----------------------------------------------------------------------------
// csvt_parser
// Parse state and the single-pass step logic: one byte in, up to two
// results out, next mode and field counters.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_parser #(
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_FIELD_LEN = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic          fire,
  input  csvt_pkg::item_t    item,
  output csvt_pkg::push_t    push
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LW = $clog2(MAX_FIELD_LEN);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_FIELD_LEN - 1);

  logic [7:0]      delimiter;
  csvt_pkg::mode_t mode, mode_next;
  logic [CW-1:0]   col, col_next;
  logic [LW-1:0]   stored, stored_next;
  logic [LW-1:0]   trimmed, trimmed_next;
  logic            quoted, quoted_next;

  logic [7:0] c;
  logic       is_d, is_q, is_cr, is_lf, is_blank;

  csvt_pkg::mode_t m_w;
  logic [CW-1:0]   col_w;
  logic [LW-1:0]   sl_w, tl_w;
  logic            q_w;
  logic            go_start, go_u, go_skip, go_qstore, go_rb, end_d, end_e, row_w;

  logic            fin_a, fa_row, fa_q, wr, fin_b;
  logic [LW-1:0]   fa_len, wr_pos, fb_len;
  logic [CW-1:0]   fa_col, wr_col;
  logic [CW+4:0]   fa_col_x, wr_col_x, fb_col_x;
  logic [LW+7:0]   fa_len_x, wr_pos_x, fb_len_x;
  csvt_pkg::res_t  res_fa, res_wr, res_fb;
  logic [1:0]      n;

  assign c        = item.data_byte;
  assign is_d     = (c == delimiter);
  assign is_q     = (c == csvt_pkg::CH_QUOTE);
  assign is_cr    = (c == csvt_pkg::CH_CR);
  assign is_lf    = (c == csvt_pkg::CH_LF);
  assign is_blank = (c == csvt_pkg::CH_SPACE) || (c == csvt_pkg::CH_TAB) ||
                    (c == csvt_pkg::CH_VT) || (c == csvt_pkg::CH_FF) || is_cr || is_lf;

  // main step
  always_comb begin
    m_w = mode; col_w = col; sl_w = stored; tl_w = trimmed; q_w = quoted;
    go_start = 1'b0; go_u = 1'b0; go_skip = 1'b0; go_qstore = 1'b0; go_rb = 1'b0;
    end_d = 1'b0; end_e = 1'b0; row_w = 1'b0;
    fin_a = 1'b0; fa_row = 1'b0; fa_q = 1'b0; fa_len = '0; fa_col = col;
    wr = 1'b0; wr_pos = '0; wr_col = col;

    unique case (mode)
      csvt_pkg::MODE_FIELD_START: go_start = 1'b1;
      csvt_pkg::MODE_UNQUOTED:    go_u = 1'b1;
      csvt_pkg::MODE_FULL: begin
        if (is_d) begin
          go_u = 1'b1;
        end else begin
          fin_a  = 1'b1;
          fa_row = 1'b1;
          fa_len = quoted ? stored : trimmed;
          fa_q   = quoted;
          fa_col = col;
          col_w  = '0;
          sl_w   = '0;
          tl_w   = '0;
          q_w    = 1'b0;
          go_rb  = 1'b1;
        end
      end
      csvt_pkg::MODE_QUOTED: begin
        if (is_q) m_w = csvt_pkg::MODE_QUOTE_SEEN;
        else go_qstore = 1'b1;
      end
      csvt_pkg::MODE_QUOTE_SEEN: begin
        if (is_q) begin
          go_qstore = 1'b1;
        end else begin
          m_w     = csvt_pkg::MODE_SKIP;
          go_skip = 1'b1;
        end
      end
      csvt_pkg::MODE_SKIP:     go_skip = 1'b1;
      csvt_pkg::MODE_EOL_SKIP: go_rb = 1'b1;
      csvt_pkg::MODE_AFTER_CR: begin
        m_w = csvt_pkg::MODE_FIELD_START;
        if (!is_lf) go_start = 1'b1;
      end
    endcase

    // row boundary
    if (go_rb) begin
      if (is_cr) m_w = csvt_pkg::MODE_AFTER_CR;
      else if (is_lf) m_w = csvt_pkg::MODE_FIELD_START;
      else go_start = 1'b1;
    end

    // field start
    if (go_start) begin
      sl_w = '0;
      tl_w = '0;
      q_w  = 1'b0;
      if (is_q) begin
        q_w = 1'b1;
        m_w = csvt_pkg::MODE_QUOTED;
      end else begin
        go_u = 1'b1;
      end
    end

    // unquoted byte
    if (go_u) begin
      if (is_d) begin
        end_d = 1'b1;
      end else if (is_cr || is_lf) begin
        end_e = 1'b1;
      end else begin
        wr     = 1'b1;
        wr_pos = sl_w;
        wr_col = col_w;
        sl_w   = sl_w + LW'(1);
        if (!is_blank) tl_w = sl_w;
        m_w = (sl_w >= LEN_FULL) ? csvt_pkg::MODE_FULL : csvt_pkg::MODE_UNQUOTED;
      end
    end

    if (go_skip) begin
      if (is_d) end_d = 1'b1;
      else if (is_cr || is_lf) end_e = 1'b1;
    end

    // quoted byte
    if (go_qstore) begin
      wr     = 1'b1;
      wr_pos = sl_w;
      wr_col = col_w;
      sl_w   = sl_w + LW'(1);
      m_w    = (sl_w >= LEN_FULL) ? csvt_pkg::MODE_SKIP : csvt_pkg::MODE_QUOTED;
    end

    // field end
    if (end_d || end_e) begin
      row_w  = end_e || (col_w == COL_LAST);
      fin_a  = 1'b1;
      fa_row = row_w;
      fa_len = q_w ? sl_w : tl_w;
      fa_q   = q_w;
      fa_col = col_w;
      col_w  = row_w ? '0 : col_w + CW'(1);
      sl_w   = '0;
      tl_w   = '0;
      q_w    = 1'b0;
      if (end_e) m_w = is_cr ? csvt_pkg::MODE_AFTER_CR : csvt_pkg::MODE_FIELD_START;
      else m_w = row_w ? csvt_pkg::MODE_EOL_SKIP : csvt_pkg::MODE_FIELD_START;
    end
  end

  // end of data and result assembly
  always_comb begin
    fin_b = item.end_of_data &&
            ((m_w == csvt_pkg::MODE_UNQUOTED) || (m_w == csvt_pkg::MODE_FULL) ||
             (m_w == csvt_pkg::MODE_QUOTED) || (m_w == csvt_pkg::MODE_QUOTE_SEEN) ||
             (m_w == csvt_pkg::MODE_SKIP) ||
             ((m_w == csvt_pkg::MODE_FIELD_START) && (col_w != '0)));
    fb_len = q_w ? sl_w : tl_w;

    fa_col_x = {5'd0, fa_col};
    wr_col_x = {5'd0, wr_col};
    fb_col_x = {5'd0, col_w};
    fa_len_x = {8'd0, fa_len};
    wr_pos_x = {8'd0, wr_pos};
    fb_len_x = {8'd0, fb_len};

    res_fa = '0;
    res_fa.column       = fa_col_x[4:0];
    res_fa.field_done   = 1'b1;
    res_fa.field_length = fa_len_x[7:0];
    res_fa.quoted_field = fa_q;
    res_fa.row_done     = fa_row;

    res_fb = '0;
    res_fb.column       = fb_col_x[4:0];
    res_fb.field_done   = 1'b1;
    res_fb.field_length = fb_len_x[7:0];
    res_fb.quoted_field = q_w;
    res_fb.row_done     = 1'b1;

    res_wr = '0;
    res_wr.write_valid = 1'b1;
    res_wr.column      = wr_col_x[4:0];
    res_wr.position    = wr_pos_x[7:0];
    res_wr.value_byte  = c;
    if (fin_b) begin
      res_wr.field_done   = 1'b1;
      res_wr.field_length = fb_len_x[7:0];
      res_wr.quoted_field = q_w;
      res_wr.row_done     = 1'b1;
    end

    push.r0 = '0;
    push.r1 = '0;
    n       = 2'd0;
    if (fin_a) begin
      push.r0 = res_fa;
      if (wr) begin
        push.r1 = res_wr;
        n = 2'd2;
      end else if (fin_b) begin
        push.r1 = res_fb;
        n = 2'd2;
      end else begin
        n = 2'd1;
      end
    end else if (wr) begin
      push.r0 = res_wr;
      n = 2'd1;
    end else if (fin_b) begin
      push.r0 = res_fb;
      n = 2'd1;
    end

    push.r0.last_of_run = (n == 2'd1);
    push.r1.last_of_run = (n == 2'd2);
    push.count = fire ? n : 2'd0;
  end

  // next state
  always_comb begin
    if (item.end_of_data) begin
      mode_next    = csvt_pkg::MODE_FIELD_START;
      col_next     = '0;
      stored_next  = '0;
      trimmed_next = '0;
      quoted_next  = 1'b0;
    end else begin
      mode_next    = m_w;
      col_next     = col_w;
      stored_next  = sl_w;
      trimmed_next = tl_w;
      quoted_next  = q_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= csvt_pkg::DELIM_RESET;
    end else if (cfg_wr_en) begin
      delimiter <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= csvt_pkg::MODE_FIELD_START;
      col     <= '0;
      stored  <= '0;
      trimmed <= '0;
      quoted  <= 1'b0;
    end else if (fire) begin
      mode    <= mode_next;
      col     <= col_next;
      stored  <= stored_next;
      trimmed <= trimmed_next;
      quoted  <= quoted_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csvt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// csvt_out_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle unless out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  csvt_pkg::push_t    push,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_stall,
  output csvt_pkg::res_t     head
);

  csvt_pkg::res_t mem [csvt_pkg::RQ_DEPTH];

  logic [csvt_pkg::RQ_AW-1:0] wp, rp;
  logic [csvt_pkg::RQ_AW:0]   count;
  logic                       pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= (csvt_pkg::RQ_AW + 1)'(csvt_pkg::RQ_DEPTH - 2));
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wp + csvt_pkg::RQ_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + csvt_pkg::RQ_AW'(push.count);
      rp    <= rp + csvt_pkg::RQ_AW'(pop);
      count <= count + (csvt_pkg::RQ_AW + 1)'(push.count)
                     - (csvt_pkg::RQ_AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csv_field_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Streaming csv tokenizer: bytes in, field writes, field ends and row ends out.
// ----------------------------------------------------------------------------
// usage
//   input channel: one text byte per item (data_byte, end_of_data) on
//   in_valid / in_stall. output channel: one result per item on
//   out_valid / out_stall; a byte gives zero, one or two results, the last
//   one flagged by last_of_run.
//   the delimiter register is loaded by cfg_wr_en / cfg_wr_data; the user must
//   load it only while idle; the block does not enforce it. a byte is held in
//   the input register, parsed by combinational logic there, and its results
//   registered in the result queue. throughput: one byte per cycle while the
//   queue has room; two results of a byte leave in turn by its single port.
//   reset: parser back to field start at column 0, delimiter back to comma,
//   result queue emptied.
//   receiver stall: results wait in a four-entry queue; input stalls once
//   fewer than two free entries remain, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_top #(
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_FIELD_LEN = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            write_valid,
  output logic [4:0]      column,
  output logic [7:0]      position,
  output logic [7:0]      value_byte,
  output logic            field_done,
  output logic [7:0]      field_length,
  output logic            quoted_field,
  output logic            row_done,
  output logic            last_of_run
);

  logic            item_valid;
  csvt_pkg::item_t item;
  logic            room;
  logic            fire;
  csvt_pkg::push_t push;
  csvt_pkg::res_t  head;

  assign fire = item_valid && room;

  csvt_in_reg u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .take        (fire),
    .item_valid  (item_valid),
    .item        (item)
  );

  csvt_parser #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .push        (push)
  );

  csvt_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign write_valid  = head.write_valid;
  assign column       = head.column;
  assign position     = head.position;
  assign value_byte   = head.value_byte;
  assign field_done   = head.field_done;
  assign field_length = head.field_length;
  assign quoted_field = head.quoted_field;
  assign row_done     = head.row_done;
  assign last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/csvt_checker.sv =====
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       write_valid,
  input wire logic [4:0] column,
  input wire logic [7:0] position,
  input wire logic [7:0] value_byte,
  input wire logic       field_done,
  input wire logic [7:0] field_length,
  input wire logic       quoted_field,
  input wire logic       row_done,
  input wire logic       last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(column) && $stable(position) &&
      $stable(value_byte) && $stable(field_length) && $stable(last_of_run))
    else $error("stalled result changed");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> position == 8'd0 && value_byte == 8'd0)
    else $error("position or byte set without a write");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !field_done |-> field_length == 8'd0 && !quoted_field && !row_done)
    else $error("field end data set without field end");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("second result of an item not ready");

endmodule

bind csv_field_tokenizer_top csvt_checker u_csvt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .write_valid  (write_valid),
  .column       (column),
  .position     (position),
  .value_byte   (value_byte),
  .field_done   (field_done),
  .field_length (field_length),
  .quoted_field (quoted_field),
  .row_done     (row_done),
  .last_of_run  (last_of_run)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives csv text one byte per item into csv_field_tokenizer_top and checks
// every field write, field end and row end against a cycle-free tokenizer
// kept alongside, under random source gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;

  localparam int MAX_COLUMNS   = 32;
  localparam int MAX_FIELD_LEN = 256;
  localparam int ITEM_TARGET   = 1700;
  localparam int IDLE_SETTLE   = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int QUIET_LIMIT   = 600;
  localparam int HOLD_CYCLES   = 80;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       end_of_data;
  logic       out_valid;
  logic       out_stall;
  logic       write_valid;
  logic [4:0] column;
  logic [7:0] position;
  logic [7:0] value_byte;
  logic       field_done;
  logic [7:0] field_length;
  logic       quoted_field;
  logic       row_done;
  logic       last_of_run;

  csv_field_tokenizer_top #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_data  (end_of_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_valid  (write_valid),
    .column       (column),
    .position     (position),
    .value_byte   (value_byte),
    .field_done   (field_done),
    .field_length (field_length),
    .quoted_field (quoted_field),
    .row_done     (row_done),
    .last_of_run  (last_of_run)
  );

  // tokenizer state mirrored by the bench
  csvt_pkg::mode_t tok_mode;
  int              tok_col;
  int              tok_len;
  int              tok_trim;
  logic            tok_quoted;
  logic [7:0]      tok_delim;
  csvt_pkg::res_t  step_out [2];
  logic            step_wr [2];
  int              step_n;

  csvt_pkg::res_t  pending_tokens [$];
  int              mismatches;
  int              items_sent;
  logic [7:0]      cur_delim;
  bit              src_idle_on;
  bit              sink_idle_on;
  int              sink_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- tokenizer

  function automatic logic is_blank(input logic [7:0] c);
    return c == csvt_pkg::CH_SPACE || c == csvt_pkg::CH_TAB || c == csvt_pkg::CH_VT ||
           c == csvt_pkg::CH_FF || c == csvt_pkg::CH_LF || c == csvt_pkg::CH_CR;
  endfunction

  function automatic void add_write(input logic [7:0] c);
    if (step_n >= 2) return;
    step_out[step_n] = '0;
    step_out[step_n].write_valid = 1'b1;
    step_out[step_n].column = tok_col[4:0];
    step_out[step_n].position = tok_len[7:0];
    step_out[step_n].value_byte = c;
    step_wr[step_n] = 1'b1;
    step_n++;
  endfunction

  function automatic void end_field(input logic row_end);
    int k;
    int len;
    len = tok_quoted ? tok_len : tok_trim;
    k = step_n - 1;
    if (!(k >= 0 && step_wr[k] && !step_out[k].field_done &&
          step_out[k].column == tok_col[4:0])) begin
      if (step_n < 2) begin
        k = step_n;
        step_out[k] = '0;
        step_out[k].column = tok_col[4:0];
        step_wr[k] = 1'b0;
        step_n++;
      end else begin
        k = -1;
      end
    end
    if (k >= 0) begin
      step_out[k].field_done = 1'b1;
      step_out[k].field_length = len[7:0];
      step_out[k].quoted_field = tok_quoted;
      step_out[k].row_done = row_end;
    end
    tok_col = row_end ? 0 : tok_col + 1;
    tok_len = 0;
    tok_trim = 0;
    tok_quoted = 1'b0;
  endfunction

  function automatic void end_by_delimiter();
    if (tok_col + 1 >= MAX_COLUMNS) begin
      end_field(1'b1);
      tok_mode = csvt_pkg::MODE_EOL_SKIP;
    end else begin
      end_field(1'b0);
      tok_mode = csvt_pkg::MODE_FIELD_START;
    end
  endfunction

  function automatic void end_by_eol(input logic [7:0] c);
    end_field(1'b1);
    tok_mode = (c == csvt_pkg::CH_CR) ? csvt_pkg::MODE_AFTER_CR : csvt_pkg::MODE_FIELD_START;
  endfunction

  function automatic void unquoted_byte(input logic [7:0] c);
    if (c == tok_delim) begin
      end_by_delimiter();
    end else if (c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF) begin
      end_by_eol(c);
    end else begin
      add_write(c);
      tok_len++;
      if (!is_blank(c)) tok_trim = tok_len;
      tok_mode = (tok_len >= MAX_FIELD_LEN - 1) ? csvt_pkg::MODE_FULL
                                                : csvt_pkg::MODE_UNQUOTED;
    end
  endfunction

  function automatic void start_field(input logic [7:0] c);
    tok_len = 0;
    tok_trim = 0;
    tok_quoted = 1'b0;
    if (c == csvt_pkg::CH_QUOTE) begin
      tok_quoted = 1'b1;
      tok_mode = csvt_pkg::MODE_QUOTED;
    end else begin
      unquoted_byte(c);
    end
  endfunction

  function automatic void row_boundary(input logic [7:0] c);
    tok_mode = csvt_pkg::MODE_FIELD_START;
    if (c == csvt_pkg::CH_CR) tok_mode = csvt_pkg::MODE_AFTER_CR;
    else if (c != csvt_pkg::CH_LF) start_field(c);
  endfunction

  function automatic void skip_byte(input logic [7:0] c);
    if (c == tok_delim) end_by_delimiter();
    else if (c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF) end_by_eol(c);
  endfunction

  function automatic void quoted_store(input logic [7:0] c);
    add_write(c);
    tok_len++;
    tok_mode = (tok_len >= MAX_FIELD_LEN - 1) ? csvt_pkg::MODE_SKIP : csvt_pkg::MODE_QUOTED;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic last);
    int i;
    step_n = 0;
    step_wr[0] = 1'b0;
    step_wr[1] = 1'b0;
    case (tok_mode)
      csvt_pkg::MODE_FIELD_START: start_field(c);
      csvt_pkg::MODE_UNQUOTED: unquoted_byte(c);
      csvt_pkg::MODE_FULL: begin
        if (c == tok_delim) begin
          end_by_delimiter();
        end else begin
          end_field(1'b1);
          row_boundary(c);
        end
      end
      csvt_pkg::MODE_QUOTED: begin
        if (c == csvt_pkg::CH_QUOTE) tok_mode = csvt_pkg::MODE_QUOTE_SEEN;
        else quoted_store(c);
      end
      csvt_pkg::MODE_QUOTE_SEEN: begin
        if (c == csvt_pkg::CH_QUOTE) begin
          quoted_store(c);
        end else begin
          tok_mode = csvt_pkg::MODE_SKIP;
          skip_byte(c);
        end
      end
      csvt_pkg::MODE_SKIP: skip_byte(c);
      csvt_pkg::MODE_EOL_SKIP: row_boundary(c);
      default: begin
        tok_mode = csvt_pkg::MODE_FIELD_START;
        if (c != csvt_pkg::CH_LF) start_field(c);
      end
    endcase
    if (last) begin
      if (tok_mode == csvt_pkg::MODE_UNQUOTED || tok_mode == csvt_pkg::MODE_FULL ||
          tok_mode == csvt_pkg::MODE_QUOTED || tok_mode == csvt_pkg::MODE_QUOTE_SEEN ||
          tok_mode == csvt_pkg::MODE_SKIP ||
          (tok_mode == csvt_pkg::MODE_FIELD_START && tok_col != 0)) begin
        end_field(1'b1);
      end
      tok_mode = csvt_pkg::MODE_FIELD_START;
      tok_col = 0;
      tok_len = 0;
      tok_trim = 0;
      tok_quoted = 1'b0;
    end
    if (step_n > 0) step_out[step_n - 1].last_of_run = 1'b1;
    for (i = 0; i < step_n; i++) pending_tokens.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_token(input csvt_pkg::res_t got);
    csvt_pkg::res_t want;
    if (pending_tokens.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected, expected nothing actual %h", $time, got);
      return;
    end
    want = pending_tokens.pop_front();
    check_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
    check_field("column", 8'(want.column), 8'(got.column));
    check_field("position", want.position, got.position);
    check_field("value_byte", want.value_byte, got.value_byte);
    check_field("field_done", 8'(want.field_done), 8'(got.field_done));
    check_field("field_length", want.field_length, got.field_length);
    check_field("quoted_field", 8'(want.quoted_field), 8'(got.quoted_field));
    check_field("row_done", 8'(want.row_done), 8'(got.row_done));
    check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
  endtask

  always @(posedge clk) begin
    csvt_pkg::res_t seen;
    if (rst) begin
      tok_mode = csvt_pkg::MODE_FIELD_START;
      tok_col = 0;
      tok_len = 0;
      tok_trim = 0;
      tok_quoted = 1'b0;
      tok_delim = csvt_pkg::DELIM_RESET;
      pending_tokens.delete();
    end else begin
      if (cfg_wr_en) tok_delim = cfg_wr_data;
      if (in_valid && !in_stall) tokenize_byte(data_byte, end_of_data);
      if (out_valid && !out_stall) begin
        seen.write_valid = write_valid;
        seen.column = column;
        seen.position = position;
        seen.value_byte = value_byte;
        seen.field_done = field_done;
        seen.field_length = field_length;
        seen.quoted_field = quoted_field;
        seen.row_done = row_done;
        seen.last_of_run = last_of_run;
        check_token(seen);
      end
    end
  end

  // result receiver
  initial begin
    int wait_n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (sink_hold_req) @(negedge clk);
        sink_hold_req = 0;
      end
      wait_n = sink_idle_on ? $urandom_range(0, 14) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 79) == 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] d);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_delim = d;
  endtask

  function automatic logic [7:0] field_byte(input logic quoted);
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = csvt_pkg::CH_SPACE;
      1: b = csvt_pkg::CH_TAB;
      2: b = ($urandom_range(0, 1) == 1) ? csvt_pkg::CH_VT : csvt_pkg::CH_FF;
      default: b = 8'($urandom_range(0, 255));
    endcase
    while ((quoted && b == csvt_pkg::CH_QUOTE) ||
           (!quoted && (b == cur_delim || b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF)))
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_field();
    int n;
    int i;
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) begin
      put_byte(csvt_pkg::CH_QUOTE);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          put_byte(csvt_pkg::CH_QUOTE);
          put_byte(csvt_pkg::CH_QUOTE);
        end else begin
          put_byte(field_byte(1'b1));
        end
      end
      put_byte(csvt_pkg::CH_QUOTE);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) put_byte(field_byte(1'b0));
    end else begin
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) begin
        b = field_byte(1'b0);
        if (i == 0 && b == csvt_pkg::CH_QUOTE) b = 8'h41;
        put_byte(b);
      end
    end
  endtask

  task automatic send_row();
    int nf;
    int f;
    nf = ($urandom_range(0, 14) == 0) ? $urandom_range(MAX_COLUMNS - 2, MAX_COLUMNS + 2)
                                      : $urandom_range(1, 5);
    for (f = 0; f < nf; f++) begin
      if (f > 0) put_byte(cur_delim);
      send_field();
    end
    case ($urandom_range(0, 3))
      0: put_byte(csvt_pkg::CH_CR);
      1: begin
        put_byte(csvt_pkg::CH_CR);
        put_byte(csvt_pkg::CH_LF);
      end
      default: put_byte(csvt_pkg::CH_LF);
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(csvt_pkg::CH_SPACE, 1'b0);
    send_byte(csvt_pkg::CH_TAB, 1'b0);
    send_byte(cur_delim, 1'b0);
    send_byte(csvt_pkg::CH_QUOTE, 1'b0);
    send_byte(csvt_pkg::CH_QUOTE, 1'b0);
    send_byte(csvt_pkg::CH_QUOTE, 1'b0);
    send_byte(cur_delim, 1'b0);
    send_byte(csvt_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(csvt_pkg::CH_CR, 1'b0);
    send_byte(csvt_pkg::CH_LF, 1'b0);
    send_byte(cur_delim, 1'b0);
    send_byte(csvt_pkg::CH_VT, 1'b0);
    send_byte(csvt_pkg::CH_FF, 1'b0);
    send_byte(csvt_pkg::CH_LF, 1'b0);
    send_byte(csvt_pkg::CH_CR, 1'b0);
    send_byte(csvt_pkg::CH_CR, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(cur_delim, 1'b1);
    send_byte(csvt_pkg::CH_QUOTE, 1'b1);
    send_byte(8'h7A, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(csvt_pkg::CH_CR, 1'b1);
  endtask

  task automatic test_full_fields();
    logic [7:0] enders [3];
    int i;
    int k;
    src_idle_on = 1'b0;
    sink_idle_on = ($urandom_range(0, 1) == 1);
    enders[0] = cur_delim;
    enders[1] = 8'h78;
    enders[2] = csvt_pkg::CH_CR;
    for (k = 0; k < 3; k++) begin
      for (i = 0; i < MAX_FIELD_LEN - 1; i++)
        send_byte((i >= MAX_FIELD_LEN - 4) ? csvt_pkg::CH_SPACE : 8'(8'h41 + i % 26), 1'b0);
      send_byte(enders[k], 1'b0);
      send_byte(csvt_pkg::CH_LF, 1'b0);
    end
    send_byte(csvt_pkg::CH_QUOTE, 1'b0);
    for (i = 0; i < MAX_FIELD_LEN + 2; i++)
      send_byte((i == MAX_FIELD_LEN) ? csvt_pkg::CH_QUOTE : 8'(8'h30 + i % 10), 1'b0);
    send_byte(csvt_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_last_column();
    int i;
    int k;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    for (k = 0; k < 3; k++) begin
      for (i = 0; i < MAX_COLUMNS; i++) begin
        send_byte(8'(8'h61 + k), 1'b0);
        send_byte(cur_delim, k == 2 && i == MAX_COLUMNS - 1);
      end
      if (k == 0) begin
        send_byte(csvt_pkg::CH_CR, 1'b0);
        send_byte(csvt_pkg::CH_LF, 1'b0);
      end else if (k == 1) begin
        send_byte(8'h7A, 1'b0);
        send_byte(csvt_pkg::CH_LF, 1'b0);
      end
    end
    // row end by cr on the last byte, then the lf is a row of its own
    send_byte(8'h61, 1'b0);
    send_byte(csvt_pkg::CH_CR, 1'b1);
    send_byte(csvt_pkg::CH_LF, 1'b0);
    send_byte(csvt_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    for (i = 0; i < 60; i++)
      send_byte((i % 7 == 6) ? cur_delim : 8'(8'h61 + i % 26), 1'b0);
    send_byte(csvt_pkg::CH_LF, 1'b0);
  endtask

  task automatic test_random_rows();
    logic [7:0] delims [10];
    int p;
    int quota;
    delims = '{8'h2C, 8'h3B, csvt_pkg::CH_TAB, 8'h00, 8'hFF, csvt_pkg::CH_QUOTE,
               csvt_pkg::CH_CR, csvt_pkg::CH_LF, 8'h7C, csvt_pkg::DELIM_RESET};
    for (p = 0; p < 10; p++) begin
      write_delimiter(delims[p]);
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      quota = items_sent + (ITEM_TARGET - items_sent) / (10 - p);
      while (items_sent < quota) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        else
          send_row();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    in_valid = 1'b0;
    data_byte = 8'h00;
    end_of_data = 1'b0;
    mismatches = 0;
    items_sent = 0;
    cur_delim = csvt_pkg::DELIM_RESET;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    sink_hold_req = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_full_fields();
    test_last_column();
    test_backpressure();
    test_random_rows();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
